FILE: hdl/lfsc_pkg.sv
package lfsc_pkg;

    localparam int unsigned COUNTER_BITS_DEF = 20;

    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned DIFF_W   = 8;
    localparam int unsigned DRIVE_W  = 9;
    localparam int unsigned GAIN_W   = 8;
    localparam int unsigned BAND_W   = 7;
    localparam int unsigned FULL_W   = 8;
    localparam int unsigned PERIOD_W = 20;
    localparam int unsigned MODE_W   = 2;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 20;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_DRIVE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_PERIODS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_PERIODS    = 3'd4;

    localparam logic [GAIN_W-1:0]   GAIN_RST    = 8'd12;
    localparam logic [BAND_W-1:0]   BAND_RST    = 7'd5;
    localparam logic [FULL_W-1:0]   FULL_RST    = 8'd255;
    localparam logic [PERIOD_W-1:0] REVERSE_RST = 20'd1000;
    localparam logic [PERIOD_W-1:0] SPIN_RST    = 20'd3000;

    // Mode codes as they appear on the result.
    localparam logic [MODE_W-1:0] MODE_CODE_FOLLOW  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_REVERSE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CODE_SPIN    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CODE_SEARCH  = 2'd3;

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 9'sd255;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -9'sd255;

    typedef enum logic [3:0] {
        M_FOLLOW  = 4'b0001,
        M_REVERSE = 4'b0010,
        M_SPIN    = 4'b0100,
        M_SEARCH  = 4'b1000
    } t_mode;

    function automatic logic [MODE_W-1:0] mode_code(input t_mode m);
        logic [MODE_W-1:0] c;
        unique case (m)
            M_FOLLOW:  c = MODE_CODE_FOLLOW;
            M_REVERSE: c = MODE_CODE_REVERSE;
            M_SPIN:    c = MODE_CODE_SPIN;
            M_SEARCH:  c = MODE_CODE_SEARCH;
            default:   c = MODE_CODE_FOLLOW;
        endcase
        return c;
    endfunction

    function automatic logic signed [DRIVE_W-1:0] sat_drive(input logic signed [17:0] v);
        logic signed [DRIVE_W-1:0] r;
        if (v > 18'(DRIVE_MAX)) begin
            r = DRIVE_MAX;
        end else if (v < 18'(DRIVE_MIN)) begin
            r = DRIVE_MIN;
        end else begin
            r = v[DRIVE_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/line_follow_steering_controller_unit.sv
// Channel   Valid        Ready        Payload
// config    i_cfg_valid  o_cfg_ready  i_cfg_index, i_cfg_data
// sample    i_in_valid   o_in_ready   i_left_count, i_right_count, i_pixel_diff,
//                                     i_hint_left, i_hint_right, i_obstacle
// result    o_out_valid  i_out_ready  o_left_drive, o_right_drive, o_led_left,
//                                     o_led_right, o_mode_now
//
// One sample per cycle while the result is not stalled.
// The input register feeds one pass of steering logic into the result register.
// Reset is synchronous, active low; restores config, clears valid flags and state.
// A stalled result holds the result register, and the input register still
// accepts one further sample behind it.
module line_follow_steering_controller_unit #(
    parameter int unsigned COUNTER_BITS = lfsc_pkg::COUNTER_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [lfsc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [lfsc_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [lfsc_pkg::COUNT_W-1:0]           i_left_count,
    input  logic [lfsc_pkg::COUNT_W-1:0]           i_right_count,
    input  logic signed [lfsc_pkg::DIFF_W-1:0]     i_pixel_diff,
    input  logic                                   i_hint_left,
    input  logic                                   i_hint_right,
    input  logic                                   i_obstacle,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [lfsc_pkg::DRIVE_W-1:0]    o_left_drive,
    output logic signed [lfsc_pkg::DRIVE_W-1:0]    o_right_drive,
    output logic                                   o_led_left,
    output logic                                   o_led_right,
    output logic [lfsc_pkg::MODE_W-1:0]            o_mode_now
);
    import lfsc_pkg::*;

    localparam int unsigned CMP_W = ((COUNTER_BITS > PERIOD_W) ? COUNTER_BITS : PERIOD_W) + 1;
    localparam logic [COUNTER_BITS:0] CNT_MAX = {1'b0, {COUNTER_BITS{1'b1}}};

    // Configuration registers.
    logic [GAIN_W-1:0]   r_gain;
    logic [BAND_W-1:0]   r_band;
    logic [FULL_W-1:0]   r_full;
    logic [PERIOD_W-1:0] r_rev_per;
    logic [PERIOD_W-1:0] r_spin_per;

    // Input register.
    logic                       r_in_valid;
    logic [COUNT_W-1:0]         r_lc;
    logic [COUNT_W-1:0]         r_rc;
    logic signed [DIFF_W-1:0]   r_diff;
    logic                       r_hl;
    logic                       r_hr;
    logic                       r_obs;

    // Controller state.
    t_mode                      r_mode;
    logic [COUNTER_BITS-1:0]    r_cnt;
    logic signed [DRIVE_W-1:0]  r_last_ld;
    logic signed [DRIVE_W-1:0]  r_last_rd;

    // Result register.
    logic                       r_out_valid;
    logic signed [DRIVE_W-1:0]  r_out_ld;
    logic signed [DRIVE_W-1:0]  r_out_rd;
    logic                       r_out_ll;
    logic                       r_out_lr;
    logic [MODE_W-1:0]          r_out_mode;

    t_mode                      n_mode;
    logic [COUNTER_BITS-1:0]    n_cnt;
    logic signed [DRIVE_W-1:0]  n_ld;
    logic signed [DRIVE_W-1:0]  n_rd;
    logic                       n_ll;
    logic                       n_lr;

    logic s2_free;
    logic s2_load;
    logic in_take;

    logic line_lost;
    logic in_follow;
    logic enter_rev;
    logic in_rev;
    logic in_spin;
    logic [COUNTER_BITS-1:0] cnt_base;
    logic [COUNTER_BITS:0]   cnt_inc;
    logic [PERIOD_W-1:0]     limit;
    logic                    done;

    logic signed [DRIVE_W-1:0] fpos;
    logic signed [DRIVE_W-1:0] fneg;
    logic signed [16:0]        gd;
    logic signed [17:0]        l_prop;
    logic signed [17:0]        r_prop;
    logic signed [DIFF_W:0]    diff_x;
    logic signed [DIFF_W:0]    band_pos;
    logic signed [DIFF_W:0]    band_neg;

    assign o_cfg_ready = 1'b1;

    assign s2_free    = !r_out_valid || i_out_ready;
    assign s2_load    = r_in_valid && s2_free;
    assign o_in_ready = !r_in_valid || s2_free;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= GAIN_RST;
            r_band     <= BAND_RST;
            r_full     <= FULL_RST;
            r_rev_per  <= REVERSE_RST;
            r_spin_per <= SPIN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STEER_GAIN:      r_gain     <= i_cfg_data[GAIN_W-1:0];
                CFG_DEAD_BAND:       r_band     <= i_cfg_data[BAND_W-1:0];
                CFG_FULL_DRIVE:      r_full     <= i_cfg_data[FULL_W-1:0];
                CFG_REVERSE_PERIODS: r_rev_per  <= i_cfg_data[PERIOD_W-1:0];
                CFG_SPIN_PERIODS:    r_spin_per <= i_cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_lc   <= i_left_count;
            r_rc   <= i_right_count;
            r_diff <= i_pixel_diff;
            r_hl   <= i_hint_left;
            r_hr   <= i_hint_right;
            r_obs  <= i_obstacle;
        end
    end

    // Mode decode. A search that sees the line falls back to following on the
    // same sample, and an obstacle seen while following starts reversing at once.
    assign line_lost = (r_lc == '0) && (r_rc == '0);
    assign in_follow = (r_mode == M_FOLLOW) || ((r_mode == M_SEARCH) && !line_lost);
    assign enter_rev = in_follow && r_obs;
    assign in_rev    = (r_mode == M_REVERSE) || enter_rev;
    assign in_spin   = (r_mode == M_SPIN);

    assign cnt_base = enter_rev ? '0 : r_cnt;
    assign cnt_inc  = {1'b0, cnt_base} + 1'b1;
    assign limit    = in_rev ? r_rev_per : r_spin_per;
    assign done     = (CMP_W'(cnt_inc) >= CMP_W'(limit)) || (cnt_inc == CNT_MAX);

    assign fpos     = $signed({1'b0, r_full});
    assign fneg     = -fpos;
    assign gd       = $signed({1'b0, r_gain}) * r_diff;
    assign l_prop   = 18'(fpos) - 18'(gd);
    assign r_prop   = 18'(fpos) + 18'(gd);
    assign diff_x   = 9'(r_diff);
    assign band_pos = $signed({2'b00, r_band});
    assign band_neg = -band_pos;

    always_comb begin
        n_mode = r_mode;
        n_cnt  = r_cnt;
        n_ld   = '0;
        n_rd   = '0;
        n_ll   = 1'b0;
        n_lr   = 1'b0;
        if (in_rev) begin
            n_ld   = fneg;
            n_rd   = fneg;
            n_cnt  = done ? '0 : cnt_inc[COUNTER_BITS-1:0];
            n_mode = done ? M_SPIN : M_REVERSE;
        end else if (in_spin) begin
            n_ld   = fneg;
            n_rd   = fpos;
            n_cnt  = done ? '0 : cnt_inc[COUNTER_BITS-1:0];
            n_mode = (done && !r_obs) ? M_SEARCH : M_SPIN;
        end else if (in_follow) begin
            n_mode = M_FOLLOW;
            if (line_lost) begin
                if (r_hr) begin
                    n_ld = fpos;
                    n_rd = fneg;
                end else if (r_hl) begin
                    n_ld = fneg;
                    n_rd = fpos;
                end else begin
                    n_ld = r_last_ld;
                    n_rd = r_last_rd;
                end
            end else if (diff_x > band_pos) begin
                n_ll = 1'b1;
                n_ld = (r_rc == '0) ? '0 : sat_drive(l_prop);
                n_rd = fpos;
            end else if (diff_x < band_neg) begin
                n_lr = 1'b1;
                n_ld = fpos;
                n_rd = (r_lc == '0) ? '0 : sat_drive(r_prop);
            end else begin
                n_ld = fpos;
                n_rd = fpos;
            end
        end else begin
            // Searching with no line in view: keep spinning.
            n_ld = fneg;
            n_rd = fpos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_FOLLOW;
            r_cnt     <= '0;
            r_last_ld <= '0;
            r_last_rd <= '0;
        end else if (s2_load) begin
            r_mode    <= n_mode;
            r_cnt     <= n_cnt;
            r_last_ld <= n_ld;
            r_last_rd <= n_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_out_ld   <= n_ld;
            r_out_rd   <= n_rd;
            r_out_ll   <= n_ll;
            r_out_lr   <= n_lr;
            r_out_mode <= mode_code(n_mode);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_drive  = r_out_ld;
    assign o_right_drive = r_out_rd;
    assign o_led_left    = r_out_ll;
    assign o_led_right   = r_out_lr;
    assign o_mode_now    = r_out_mode;

    // The phase counter only runs during reversing and spinning.
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_FOLLOW || r_mode == M_SEARCH) |-> (r_cnt == '0))
        else $error("phase counter not clear outside reverse and spin");

    a_cnt_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != {COUNTER_BITS{1'b1}})
        else $error("phase counter reached its maximum");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !s2_load) |=> ($stable(r_mode) && $stable(r_cnt) && $stable(r_last_ld)))
        else $error("controller state changed without a request");

    a_led_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_ll && r_out_lr))
        else $error("both indicators lit");

    a_led_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_mode != MODE_CODE_FOLLOW) |-> (!r_out_ll && !r_out_lr))
        else $error("indicator lit outside following");

    a_search_spin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_mode == MODE_CODE_SEARCH) |-> (r_out_ld == -r_out_rd))
        else $error("search result is not a spin");

endmodule
